// File: rtl/bsl_pkg.sv
// bsl_pkg: shared constants, register codes and types for the tempo-synced sine LFO.
// No dependencies. Used by bsl_step_div and bpm_synced_sine_lfo.
package bsl_pkg;

    // Default geometry
    localparam int TABLE_SIZE_DEF   = 1024;
    localparam int FRAC_BITS_DEF    = 24;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Configuration register widths
    localparam int BPM_W      = 9;
    localparam int RNUM_W     = 5;
    localparam int RDEN_W     = 5;
    localparam int SR_W       = 18;
    localparam int AMP_W      = 16;
    localparam int SPH_W      = 5;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 3;

    // Configuration reset values
    localparam int BPM_RST  = 100;
    localparam int RNUM_RST = 1;
    localparam int RDEN_RST = 1;
    localparam int SR_RST   = 48000;
    localparam int AMP_RST  = 65535;
    localparam int SPH_RST  = 0;

    // Register index map
    localparam logic [CFG_IDX_W-1:0] REG_BPM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RNUM  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RDEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRATE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AMP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPH   = 3'd5;

    localparam int SEC_PER_MIN = 60;
    localparam int START_STEPS = 24;    // start phase resolution per cycle

    // Registers that set the phase increment
    typedef struct packed {
        logic [BPM_W-1:0]  bpm;
        logic [RNUM_W-1:0] rnum;
        logic [RDEN_W-1:0] rden;
        logic [SR_W-1:0]   srate;
    } rate_cfg_t;

endpackage

// File: rtl/bsl_sine_rom.sv
// bsl_sine_rom: full-cycle sine lookup ROM with registered read data.
// Contents are generated at elaboration (quadrant fold plus Q30 series). No package use.
module bsl_sine_rom #(
    parameter int TABLE_SIZE   = 1024,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rd_en,
    input  logic [$clog2(TABLE_SIZE)-1:0]         addr,
    output logic signed [SAMPLE_WIDTH-1:0]        q
);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;

    // Series term divisors (n+1)*(n+2) for n = 0..25
    localparam longint unsigned SERIES_DIV [26] = '{
        64'd2,   64'd6,   64'd12,  64'd20,  64'd30,  64'd42,  64'd56,
        64'd72,  64'd90,  64'd110, 64'd132, 64'd156, 64'd182, 64'd210,
        64'd240, 64'd272, 64'd306, 64'd342, 64'd380, 64'd420, 64'd462,
        64'd506, 64'd552, 64'd600, 64'd650, 64'd702
    };

    typedef logic signed [SAMPLE_WIDTH-1:0] rom_t [TABLE_SIZE];

    // Taylor series in Q30: odd picks sine, else cosine; partial products truncated
    function automatic longint unsigned series_q30(longint unsigned theta, bit odd);
        longint unsigned th2;
        longint unsigned term;
        int              n;
        longint          acc;
        th2  = (theta * theta) >> 30;
        term = odd ? theta : ONE_Q30;
        acc  = longint'(term);
        n    = odd ? 1 : 0;
        for (int i = 1; i < 14; i++) begin
            term = ((term * th2) >> 30) / SERIES_DIV[n];
            n    = n + 2;
            if (i % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > longint'(ONE_Q30))
            acc = longint'(ONE_Q30);
        return longint'(acc);
    endfunction

    function automatic rom_t build_rom();
        rom_t            t;
        longint unsigned full;
        longint unsigned q4;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned theta;
        longint unsigned v;
        longint          mag;
        full = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;
        for (int k = 0; k < TABLE_SIZE; k++) begin
            q4    = 64'd4 * 64'(k);
            quad  = q4 / TABLE_SIZE;
            rem   = q4 - quad * TABLE_SIZE;
            theta = rem * HALF_PI_Q30 / TABLE_SIZE;
            v     = series_q30(theta, quad[0] == 1'b0);
            mag   = longint'((v * full + (64'd1 << 29)) >> 30);
            t[k]  = SAMPLE_WIDTH'((quad >= 64'd2) ? -mag : mag);
        end
        return t;
    endfunction

    localparam rom_t ROM = build_rom();

    logic signed [SAMPLE_WIDTH-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
            q_reg <= ROM[addr];
    end

    assign q = q_reg;

endmodule

// File: rtl/bsl_step_div.sv
// bsl_step_div: phase increment calculator, bit-serial restoring divider.
// Depends on bsl_pkg (register widths, reset values, rate_cfg_t).
module bsl_step_div #(
    parameter int PHASE_W = $clog2(bsl_pkg::TABLE_SIZE_DEF) + bsl_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  bsl_pkg::rate_cfg_t    cfg,
    output logic                  busy,
    output logic [PHASE_W-1:0]    step
);

    localparam int DN_W    = bsl_pkg::RDEN_W + bsl_pkg::BPM_W;
    localparam int RN60_W  = bsl_pkg::RNUM_W + $clog2(bsl_pkg::SEC_PER_MIN);
    localparam int DVS_W   = RN60_W + bsl_pkg::SR_W;
    localparam int NUMER_W = DN_W + PHASE_W;
    localparam int CNT_W   = $clog2(NUMER_W + 1);

    localparam longint unsigned RST_NUMER =
        (64'(bsl_pkg::RDEN_RST) * 64'(bsl_pkg::BPM_RST)) << PHASE_W;
    localparam longint unsigned RST_DIV =
        64'(bsl_pkg::RNUM_RST) * 64'(bsl_pkg::SEC_PER_MIN) * 64'(bsl_pkg::SR_RST);
    localparam logic [PHASE_W-1:0] RST_STEP = PHASE_W'(RST_NUMER / RST_DIV);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]         state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [PHASE_W-1:0] step_reg;
    logic [DN_W-1:0]    dn_sh_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic [DVS_W-1:0]   rem_reg;
    logic [PHASE_W-1:0] quo_reg;

    logic [DN_W-1:0]    dn_next;
    logic [RN60_W-1:0]  rn60;
    logic [DVS_W-1:0]   dvs_next;
    logic [DVS_W:0]     trial;
    logic               fits;
    logic [DVS_W-1:0]   rem_next;
    logic [PHASE_W-1:0] quo_next;

    // Operands: dividend is (den*bpm) << PHASE_W, divisor num*60*rate
    assign dn_next  = DN_W'(cfg.rden) * DN_W'(cfg.bpm);
    assign rn60     = RN60_W'(cfg.rnum) * RN60_W'(bsl_pkg::SEC_PER_MIN);
    assign dvs_next = DVS_W'(rn60) * DVS_W'(cfg.srate);

    // One quotient bit per cycle; low dividend bits are zeros shifted in
    assign trial    = {rem_reg, dn_sh_reg[DN_W-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
    assign quo_next = {quo_reg[PHASE_W-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            step_reg  <= RST_STEP;
        end
        else if (start)
        begin
            state_reg <= ST_PREP;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE: ;
                ST_PREP:
                begin
                    state_reg <= ST_RUN;
                    cnt_reg   <= CNT_W'(NUMER_W);
                end
                ST_RUN:
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= ST_IDLE;
                        // zero divisor leaves the phase frozen
                        step_reg  <= (dvs_reg == '0) ? '0 : quo_next;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PREP)
        begin
            dn_sh_reg <= dn_next;
            dvs_reg   <= dvs_next;
            rem_reg   <= '0;
            quo_reg   <= '0;
        end
        else if (state_reg == ST_RUN)
        begin
            dn_sh_reg <= dn_sh_reg << 1;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign step = step_reg;

endmodule

// File: rtl/bpm_synced_sine_lfo.sv
// bpm_synced_sine_lfo: top level of the tempo-synced sine LFO.
// Depends on bsl_pkg, bsl_sine_rom and bsl_step_div.
//
// Tempo-synced sine LFO. Each transfer on the input channel is one sample
// tick carrying reset_level; each tick produces exactly one transfer of
// sample_out, in order. The block takes one tick per clock while in_ready
// is high. A tick passes the sine ROM read register, then the gain multiply
// into the output register; the output register and ROM stage each hold a
// sample, so one more tick can enter while a finished sample waits for
// out_ready. A rising edge of reset_level loads the phase with start_phase/24
// of a cycle (24 and up wrap by 24) before that tick's table read. The phase
// increment is den*bpm*TABLE_SIZE*2^FRAC_BITS/(num*60*sample_rate),
// truncated, mod one cycle, and is worked out by a one-bit-per-cycle divider:
// after a write to beats_per_minute, rate_numerator, rate_denominator or
// sample_rate, in_ready stays low until the divider is done. After reset
// the increment for the reset settings is already loaded, so there is no
// wait. TABLE_SIZE must be a power of two. Write configuration
// only with no samples in flight.
module bpm_synced_sine_lfo #(
    parameter int TABLE_SIZE   = bsl_pkg::TABLE_SIZE_DEF,
    parameter int FRAC_BITS    = bsl_pkg::FRAC_BITS_DEF,
    parameter int SAMPLE_WIDTH = bsl_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample tick channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              reset_level,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]    sample_out,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [bsl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bsl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ADDR_W  = $clog2(TABLE_SIZE);
    localparam int PHASE_W = ADDR_W + FRAC_BITS;
    localparam int PROD_W  = SAMPLE_WIDTH + bsl_pkg::AMP_W + 1;
    localparam int SPH_W   = bsl_pkg::SPH_W;

    localparam logic signed [PROD_W-1:0] ROUND_BIAS =
        PROD_W'(64'd1 << (bsl_pkg::AMP_W - 1));

    // Phase loaded on a reset edge, one entry per 1/24 of a cycle
    typedef logic [PHASE_W-1:0] load_tbl_t [bsl_pkg::START_STEPS];

    function automatic load_tbl_t build_load();
        load_tbl_t t;
        for (int s = 0; s < bsl_pkg::START_STEPS; s++)
            t[s] = PHASE_W'((64'(s) << PHASE_W) / bsl_pkg::START_STEPS);
        return t;
    endfunction

    localparam load_tbl_t LOAD_TBL = build_load();

    // ---------------- configuration registers ----------------
    logic [bsl_pkg::BPM_W-1:0]  bpm_reg;
    logic [bsl_pkg::RNUM_W-1:0] rnum_reg;
    logic [bsl_pkg::RDEN_W-1:0] rden_reg;
    logic [bsl_pkg::SR_W-1:0]   srate_reg;
    logic [bsl_pkg::AMP_W-1:0]  amp_reg;
    logic [SPH_W-1:0]           sph_reg;

    bsl_pkg::rate_cfg_t rate_cfg;
    logic               rate_start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpm_reg   <= bsl_pkg::BPM_W'(bsl_pkg::BPM_RST);
            rnum_reg  <= bsl_pkg::RNUM_W'(bsl_pkg::RNUM_RST);
            rden_reg  <= bsl_pkg::RDEN_W'(bsl_pkg::RDEN_RST);
            srate_reg <= bsl_pkg::SR_W'(bsl_pkg::SR_RST);
            amp_reg   <= bsl_pkg::AMP_W'(bsl_pkg::AMP_RST);
            sph_reg   <= SPH_W'(bsl_pkg::SPH_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bsl_pkg::REG_BPM:   bpm_reg   <= cfg_data[bsl_pkg::BPM_W-1:0];
                bsl_pkg::REG_RNUM:  rnum_reg  <= cfg_data[bsl_pkg::RNUM_W-1:0];
                bsl_pkg::REG_RDEN:  rden_reg  <= cfg_data[bsl_pkg::RDEN_W-1:0];
                bsl_pkg::REG_SRATE: srate_reg <= cfg_data[bsl_pkg::SR_W-1:0];
                bsl_pkg::REG_AMP:   amp_reg   <= cfg_data[bsl_pkg::AMP_W-1:0];
                bsl_pkg::REG_SPH:   sph_reg   <= cfg_data[SPH_W-1:0];
                default: ;          // unmapped index, write dropped
            endcase
        end
    end

    // Only the rate registers change the increment
    always_comb
    begin
        unique case (cfg_index) inside
            bsl_pkg::REG_BPM, bsl_pkg::REG_RNUM, bsl_pkg::REG_RDEN, bsl_pkg::REG_SRATE:
                rate_start = cfg_we;
            default:
                rate_start = 1'b0;
        endcase
    end

    assign rate_cfg = '{bpm: bpm_reg, rnum: rnum_reg, rden: rden_reg, srate: srate_reg};

    // ---------------- phase increment ----------------
    logic               div_busy;
    logic [PHASE_W-1:0] phase_step;

    bsl_step_div #(
        .PHASE_W (PHASE_W)
    ) u_step_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rate_start),
        .cfg   (rate_cfg),
        .busy  (div_busy),
        .step  (phase_step)
    );

    // ---------------- pipeline control ----------------
    // Stage A: ROM read register. Stage B: output register.
    logic a_valid_reg;
    logic b_valid_reg;
    logic a_adv;
    logic b_adv;
    logic accept;

    assign b_adv    = !b_valid_reg || out_ready;
    assign a_adv    = !a_valid_reg || b_adv;
    assign in_ready = a_adv && !div_busy;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
                a_valid_reg <= accept;
            if (b_adv)
                b_valid_reg <= a_valid_reg;
        end
    end

    // ---------------- phase accumulator ----------------
    logic               armed_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic               load;
    logic [SPH_W-1:0]   sph_mod;
    logic [PHASE_W-1:0] phase_cur;
    logic [PHASE_W-1:0] phase_next;

    // armed follows the last tick's level, so a load fires on 0 -> 1
    assign load       = reset_level && !armed_reg;
    assign sph_mod    = (sph_reg >= SPH_W'(bsl_pkg::START_STEPS))
                      ? SPH_W'(sph_reg - SPH_W'(bsl_pkg::START_STEPS)) : sph_reg;
    assign phase_cur  = load ? LOAD_TBL[sph_mod] : phase_reg;
    assign phase_next = phase_cur + phase_step;     // wraps at one full cycle

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            phase_reg <= '0;
        end
        else if (accept)
        begin
            armed_reg <= reset_level;
            phase_reg <= phase_next;
        end
    end

    // ---------------- sine lookup ----------------
    logic signed [SAMPLE_WIDTH-1:0] rom_q;

    bsl_sine_rom #(
        .TABLE_SIZE   (TABLE_SIZE),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_sine_rom (
        .clk   (clk),
        .rd_en (accept),
        .addr  (phase_cur[PHASE_W-1 -: ADDR_W]),
        .q     (rom_q)
    );

    // ---------------- gain and rounding ----------------
    logic signed [PROD_W-1:0]       prod;
    logic signed [PROD_W-1:0]       prod_rnd;
    logic signed [SAMPLE_WIDTH-1:0] sample_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;

    // Q1.x sample times unsigned Q0.16 gain, round half up, drop the 16 gain fraction bits
    assign prod        = signed'(PROD_W'(rom_q)) * signed'(PROD_W'({1'b0, amp_reg}));
    assign prod_rnd    = prod + ROUND_BIAS;
    assign sample_next = prod_rnd[bsl_pkg::AMP_W +: SAMPLE_WIDTH];

    always_ff @(posedge clk)
    begin
        if (b_adv && a_valid_reg)
            sample_reg <= sample_next;
    end

    assign out_valid  = b_valid_reg;
    assign sample_out = sample_reg;

`ifndef SYNTHESIS
    // A rate write must hold off new ticks while the increment is rebuilt
    a_rate_write_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rate_start |=> !in_ready)
        else $error("tick accepted window open right after rate write");

    // Edge detector tracks the level of the last transferred tick
    a_armed_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> armed_reg == $past(reset_level))
        else $error("armed flag out of step with tick level");

    // Phase moves only on a transfer
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(phase_reg))
        else $error("phase changed without a tick");

    // A sample in the ROM stage is not dropped while the output is blocked
    a_stage_a_kept: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !b_adv |=> a_valid_reg)
        else $error("ROM stage sample lost under back-pressure");

    // Increment only changes as the result of a rate write
    a_step_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !div_busy && !rate_start |=> $stable(phase_step))
        else $error("phase increment changed with divider idle");
`endif

endmodule
